FILE: rtl/btc_pkg.sv
// ----------------------------------------------------------------------------
// btc_pkg - shared types and constants for the box versus tile map checker
// Widths, register indexes, op codes, sequencer states and the probe word
// passed from the scan sequencer to the hit unit.
// ----------------------------------------------------------------------------
package btc_pkg;

  // map geometry
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;

  // register and field widths
  localparam int DIM_W  = 6;
  localparam int TSZ_W  = 8;
  localparam int TS_W   = TSZ_W + 4;   // tile side in pixels times 16
  localparam int TC_W   = 18;          // tile corner coordinate, unsigned
  localparam int POS_W  = 19;
  localparam int SIZE_W = 16;
  localparam int MOV_W  = 16;
  localparam int CRD_W  = 22;          // signed compare width
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] OPEN_CODE = 8'd48;

  localparam logic [DIM_W-1:0] MAX_ROWS_V = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] MAX_COLS_V = DIM_W'(MAX_COLS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE = 2'd2;

  // op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } seq_state_t;

  // control word from sequencer to hit unit
  typedef struct packed {
    logic            clr;    // capture box, clear hits
    logic            setup;  // form box edge sums
    logic            vld;    // tile probe valid this cycle
    logic [TC_W-1:0] tx;
    logic [TC_W-1:0] ty;
  } probe_t;

endpackage

FILE: rtl/btc_tile_mem.sv
// ----------------------------------------------------------------------------
// btc_tile_mem - solid bit store
// One bit per tile, one write port and one registered read port.
// ----------------------------------------------------------------------------
module btc_tile_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [btc_pkg::ADDR_W-1:0] waddr,
  input  logic                      wdata,
  input  logic [btc_pkg::ADDR_W-1:0] raddr,
  output logic                      rdata
);

  logic mem [btc_pkg::DEPTH];
  logic rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/btc_hit_unit.sv
// ----------------------------------------------------------------------------
// btc_hit_unit - shared edge compare unit
// Holds the query box, forms its edge sums once, then tests one tile per
// cycle for the x-moved and y-moved boxes and ors the hits.
// ----------------------------------------------------------------------------
module btc_hit_unit (
  input  logic                                clk,
  input  btc_pkg::probe_t                     probe,
  input  logic                                solid,
  input  logic [btc_pkg::TS_W-1:0]            ts,
  input  logic signed [btc_pkg::POS_W-1:0]    box_x,
  input  logic signed [btc_pkg::POS_W-1:0]    box_y,
  input  logic [btc_pkg::SIZE_W-1:0]          box_w,
  input  logic [btc_pkg::SIZE_W-1:0]          box_h,
  input  logic signed [btc_pkg::MOV_W-1:0]    move_dx,
  input  logic signed [btc_pkg::MOV_W-1:0]    move_dy,
  output logic                                x_hit,
  output logic                                y_hit
);

  localparam int CW = btc_pkg::CRD_W;

  logic signed [CW-1:0] x_r, y_r, w_r, h_r, dx_r, dy_r;
  logic signed [CW-1:0] xa_r, xae_r, xe_r, ya_r, yae_r, ye_r;
  logic signed [CW-1:0] tx_s, ty_s, txe_s, tye_s;
  logic                 ox_moved, ox_still, oy_moved, oy_still;
  logic                 x_hit_r, y_hit_r;

  // capture box on query start, extended to compare width
  always_ff @(posedge clk) begin
    if (probe.clr) begin
      x_r  <= {{(CW-btc_pkg::POS_W){box_x[btc_pkg::POS_W-1]}}, box_x};
      y_r  <= {{(CW-btc_pkg::POS_W){box_y[btc_pkg::POS_W-1]}}, box_y};
      w_r  <= {{(CW-btc_pkg::SIZE_W){1'b0}}, box_w};
      h_r  <= {{(CW-btc_pkg::SIZE_W){1'b0}}, box_h};
      dx_r <= {{(CW-btc_pkg::MOV_W){move_dx[btc_pkg::MOV_W-1]}}, move_dx};
      dy_r <= {{(CW-btc_pkg::MOV_W){move_dy[btc_pkg::MOV_W-1]}}, move_dy};
    end
  end

  // box edge sums, once per query
  always_ff @(posedge clk) begin
    if (probe.setup) begin
      xa_r  <= x_r + dx_r;
      xae_r <= x_r + dx_r + w_r;
      xe_r  <= x_r + w_r;
      ya_r  <= y_r + dy_r;
      yae_r <= y_r + dy_r + h_r;
      ye_r  <= y_r + h_r;
    end
  end

  // tile edges
  always_comb begin
    tx_s  = $signed({{(CW-btc_pkg::TC_W){1'b0}}, probe.tx});
    ty_s  = $signed({{(CW-btc_pkg::TC_W){1'b0}}, probe.ty});
    txe_s = tx_s + $signed({{(CW-btc_pkg::TS_W){1'b0}}, ts});
    tye_s = ty_s + $signed({{(CW-btc_pkg::TS_W){1'b0}}, ts});
  end

  // inclusive interval overlap per axis
  always_comb begin
    ox_moved = (xa_r <= txe_s) && (xae_r >= tx_s);
    ox_still = (x_r  <= txe_s) && (xe_r  >= tx_s);
    oy_moved = (ya_r <= tye_s) && (yae_r >= ty_s);
    oy_still = (y_r  <= tye_s) && (ye_r  >= ty_s);
  end

  // hit accumulation
  always_ff @(posedge clk) begin
    if (probe.clr) begin
      x_hit_r <= 1'b0;
      y_hit_r <= 1'b0;
    end else if (probe.vld && solid) begin
      x_hit_r <= x_hit_r | (ox_moved & oy_still);
      y_hit_r <= y_hit_r | (ox_still & oy_moved);
    end
  end

  assign x_hit = x_hit_r;
  assign y_hit = y_hit_r;

endmodule

FILE: rtl/btc_scan_seq.sv
// ----------------------------------------------------------------------------
// btc_scan_seq - query sequencer
// Walks the map area row by row, one tile per cycle, keeping the tile
// corner coordinates by repeated add of the tile side.
// ----------------------------------------------------------------------------
module btc_scan_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [btc_pkg::DIM_W-1:0]       rows,
  input  logic [btc_pkg::DIM_W-1:0]       cols,
  input  logic [btc_pkg::TS_W-1:0]        ts,
  input  logic                            out_free,
  output logic                            idle,
  output logic [btc_pkg::ADDR_W-1:0]      raddr,
  output btc_pkg::probe_t                 probe,
  output logic                            load_out
);

  btc_pkg::seq_state_t state_r, state_nxt;

  logic [btc_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [btc_pkg::COL_W-1:0] col_r, col_nxt;
  logic [btc_pkg::TC_W-1:0]  tx_r, tx_nxt, ty_r, ty_nxt;
  logic [btc_pkg::TC_W-1:0]  stx_r, sty_r;
  logic                      svld_r, svld_nxt;
  logic                      last_col, last_row;
  logic [btc_pkg::TC_W-1:0]  ts_ext;

  assign ts_ext   = {{(btc_pkg::TC_W-btc_pkg::TS_W){1'b0}}, ts};
  assign last_col = {1'b0, col_r} == (cols - 1'b1);
  assign last_row = {1'b0, row_r} == (rows - 1'b1);

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    svld_nxt  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      btc_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = btc_pkg::ST_SETUP;
        end
      end
      btc_pkg::ST_SETUP: begin
        row_nxt = '0;
        col_nxt = '0;
        tx_nxt  = '0;
        ty_nxt  = '0;
        if (rows == '0 || cols == '0) begin
          state_nxt = btc_pkg::ST_DRAIN;
        end else begin
          state_nxt = btc_pkg::ST_SCAN;
        end
      end
      btc_pkg::ST_SCAN: begin
        svld_nxt = 1'b1;
        if (last_col) begin
          col_nxt = '0;
          tx_nxt  = '0;
          row_nxt = row_r + 1'b1;
          ty_nxt  = ty_r + ts_ext;
          if (last_row) begin
            state_nxt = btc_pkg::ST_DRAIN;
          end
        end else begin
          col_nxt = col_r + 1'b1;
          tx_nxt  = tx_r + ts_ext;
        end
      end
      btc_pkg::ST_DRAIN: begin
        state_nxt = btc_pkg::ST_DONE;
      end
      btc_pkg::ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = btc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = btc_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btc_pkg::ST_IDLE;
      svld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      svld_r  <= svld_nxt;
    end
  end

  // counters and probe stage, aligned with the memory read
  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
    tx_r  <= tx_nxt;
    ty_r  <= ty_nxt;
    stx_r <= tx_r;
    sty_r <= ty_r;
  end

  assign idle        = (state_r == btc_pkg::ST_IDLE);
  assign raddr       = {row_r, col_r};
  assign probe.clr   = start;
  assign probe.setup = (state_r == btc_pkg::ST_SETUP);
  assign probe.vld   = svld_r;
  assign probe.tx    = stx_r;
  assign probe.ty    = sty_r;

endmodule

FILE: rtl/box_tilemap_collision.sv
// ----------------------------------------------------------------------------
// box_tilemap_collision - per-axis box versus tile map collision test
// Keeps one solid bit per tile and answers box queries by scanning the map.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel carries one word per item. op = write stores one tile (solid
//   unless its code is '0') and gives no result; op = query tests the box
//   moved by move_dx alone (x_hit) and by move_dy alone (y_hit).
//   out_* channel carries one word per query. cfg_* writes map_rows (0),
//   map_cols (1) and tile_size (2); cfg_ready is always high.
//   A query holds in_stall high through setup, a scan of one tile per cycle
//   through the single tile memory read port and compare unit, drain and
//   result load; the result shows on out_valid the cycle after the load.
//   If the receiver stalls, the result stays in the output register; the
//   next query may be taken meanwhile but waits at its end for that register.
//   Reset sets the map to 32 x 32 tiles of 32 pixels and clears the
//   handshake; tile contents are undefined until written.
// ----------------------------------------------------------------------------
module box_tilemap_collision (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input word channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_op,
  input  logic [4:0]                              in_tile_row,
  input  logic [4:0]                              in_tile_col,
  input  logic [7:0]                              in_tile_code,
  input  logic signed [btc_pkg::POS_W-1:0]        in_box_x,
  input  logic signed [btc_pkg::POS_W-1:0]        in_box_y,
  input  logic [btc_pkg::SIZE_W-1:0]              in_box_w,
  input  logic [btc_pkg::SIZE_W-1:0]              in_box_h,
  input  logic signed [btc_pkg::MOV_W-1:0]        in_move_dx,
  input  logic signed [btc_pkg::MOV_W-1:0]        in_move_dy,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_x_hit,
  output logic                                    out_y_hit,
  // configuration channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [btc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [7:0]                              cfg_data
);

  logic [btc_pkg::DIM_W-1:0] map_rows_r, map_cols_r;
  logic [btc_pkg::TSZ_W-1:0] tile_size_r;
  logic [btc_pkg::DIM_W-1:0] rows_eff, cols_eff;
  logic [btc_pkg::TS_W-1:0]  ts;

  logic                       idle, in_acc, wr_acc, q_acc, load_out, out_free;
  logic [btc_pkg::ADDR_W-1:0] raddr;
  logic                       solid;
  btc_pkg::probe_t            probe;
  logic                       x_hit, y_hit;
  logic                       out_valid_r, out_x_r, out_y_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_rows_r  <= btc_pkg::DIM_W'(32);
      map_cols_r  <= btc_pkg::DIM_W'(32);
      tile_size_r <= btc_pkg::TSZ_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        btc_pkg::REG_MAP_ROWS:  map_rows_r  <= cfg_data[btc_pkg::DIM_W-1:0];
        btc_pkg::REG_MAP_COLS:  map_cols_r  <= cfg_data[btc_pkg::DIM_W-1:0];
        btc_pkg::REG_TILE_SIZE: tile_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // map size saturation and tile side in fixed point
  assign rows_eff = (map_rows_r > btc_pkg::MAX_ROWS_V) ? btc_pkg::MAX_ROWS_V : map_rows_r;
  assign cols_eff = (map_cols_r > btc_pkg::MAX_COLS_V) ? btc_pkg::MAX_COLS_V : map_cols_r;
  assign ts       = {tile_size_r, 4'b0000};

  // input handshake
  assign in_stall = !idle;
  assign in_acc   = in_valid && !in_stall;
  assign wr_acc   = in_acc && (in_op == btc_pkg::OP_WRITE);
  assign q_acc    = in_acc && (in_op == btc_pkg::OP_QUERY);

  btc_tile_mem u_mem (
    .clk   (clk),
    .we    (wr_acc),
    .waddr ({in_tile_row, in_tile_col}),
    .wdata (in_tile_code != btc_pkg::OPEN_CODE),
    .raddr (raddr),
    .rdata (solid)
  );

  btc_scan_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (q_acc),
    .rows     (rows_eff),
    .cols     (cols_eff),
    .ts       (ts),
    .out_free (out_free),
    .idle     (idle),
    .raddr    (raddr),
    .probe    (probe),
    .load_out (load_out)
  );

  btc_hit_unit u_hit (
    .clk     (clk),
    .probe   (probe),
    .solid   (solid),
    .ts      (ts),
    .box_x   (in_box_x),
    .box_y   (in_box_y),
    .box_w   (in_box_w),
    .box_h   (in_box_h),
    .move_dx (in_move_dx),
    .move_dy (in_move_dy),
    .x_hit   (x_hit),
    .y_hit   (y_hit)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r <= x_hit;
      out_y_r <= y_hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x_hit = out_x_r;
  assign out_y_hit = out_y_r;

endmodule
